// File: hdl/rpc_pkg.sv
package rpc_pkg;

  localparam int SOURCE_SIZE_DEF = 512;
  localparam int OUT_SIZE_DEF    = 480;

  localparam int COORD_W     = 9;
  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 16;
  localparam int ADDR_W      = 18;
  localparam int SRC_CNT_W   = 19;
  localparam int DRAWN_CNT_W = 18;
  localparam int BOX_W       = 10;
  localparam int LEAST_W     = 11;
  localparam int IDX_W       = 3;
  localparam int TAB_DEPTH   = 256;

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef logic [IDX_W-1:0] rpc_idx_tab_t [TAB_DEPTH];

  typedef struct packed {
    logic                   frame_start;
    logic                   nonzero;
    logic [COORD_W-1:0]     col;
    logic [COORD_W-1:0]     row;
    logic                   enable;
    logic [ADDR_W-1:0]      addr;
    logic [COLOR_W-1:0]     written;
  } rpc_item_t;

  typedef struct packed {
    logic                    enable;
    logic [ADDR_W-1:0]       addr;
    logic [COLOR_W-1:0]      color;
    logic [SRC_CNT_W-1:0]    source_count;
    logic [DRAWN_CNT_W-1:0]  drawn_count;
    logic [BOX_W-1:0]        box_min_x;
    logic [BOX_W-1:0]        box_min_y;
    logic signed [BOX_W-1:0] box_max_x;
    logic signed [BOX_W-1:0] box_max_y;
  } rpc_result_t;

  function automatic logic [COLOR_W-1:0] pack565(int r, int g, int b);
    return COLOR_W'(((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3));
  endfunction

  localparam logic [COLOR_W-1:0] PALETTE [16] = '{
    pack565(8'h6E, 8'hFF, 8'h6E), pack565(8'h35, 8'hFF, 8'h35),
    pack565(8'h02, 8'hFD, 8'h02), pack565(8'h01, 8'hE1, 8'h01),
    pack565(8'h01, 8'hC5, 8'h01), pack565(8'h00, 8'hAC, 8'h00),
    pack565(8'h00, 8'h9A, 8'h00), pack565(8'h00, 8'h8E, 8'h00),
    pack565(8'hFD, 8'hF8, 8'h02), pack565(8'hF2, 8'hD8, 8'h00),
    pack565(8'hE5, 8'hBC, 8'h00), pack565(8'hFD, 8'h95, 8'h00),
    pack565(8'hFD, 8'h60, 8'h00), pack565(8'hFD, 8'h00, 8'h00),
    pack565(8'hBC, 8'h00, 8'h00), pack565(8'hF8, 8'h00, 8'hFD)
  };

  localparam logic [COLOR_W-1:0] TRACE_COLOR = pack565(8'h1E, 8'h46, 8'h20);
  localparam logic [COLOR_W-1:0] MAGENTA_COLOR = pack565(8'hF8, 8'h00, 8'hFD);

  function automatic int clamp_t(int t);
    int v;
    v = t;
    if (v < 0) v = 0;
    if (v > 1000) v = 1000;
    return v;
  endfunction

  // ramp position to palette index, per source channel value
  function automatic rpc_idx_tab_t build_warm_g();
    rpc_idx_tab_t tab;
    int t;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      t = clamp_t(((238 - i) * 665) / 238);
      tab[i] = IDX_W'((t * 8) / 1001);
    end
    return tab;
  endfunction

  function automatic rpc_idx_tab_t build_warm_r();
    rpc_idx_tab_t tab;
    int t;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      t = clamp_t(665 + ((255 - i) * 335) / 162);
      tab[i] = IDX_W'((t * 8) / 1001);
    end
    return tab;
  endfunction

  function automatic rpc_idx_tab_t build_cool_g();
    rpc_idx_tab_t tab;
    int t;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      t = clamp_t(((221 - i) * 1000) / 150);
      tab[i] = IDX_W'((t * 8) / 1001);
    end
    return tab;
  endfunction

  localparam rpc_idx_tab_t WARM_G_TAB = build_warm_g();
  localparam rpc_idx_tab_t WARM_R_TAB = build_warm_r();
  localparam rpc_idx_tab_t COOL_G_TAB = build_cool_g();

endpackage

// File: hdl/rpc_fifo.sv
module rpc_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push_ok, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

// File: hdl/rpc_front.sv
module rpc_front #(
  parameter int SOURCE_SIZE = rpc_pkg::SOURCE_SIZE_DEF,
  parameter int OUT_SIZE    = rpc_pkg::OUT_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_source_format,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_frame_start,
  input  logic [rpc_pkg::CHAN_W-1:0]     in_red,
  input  logic [rpc_pkg::CHAN_W-1:0]     in_green,
  input  logic [rpc_pkg::CHAN_W-1:0]     in_blue,
  input  logic [rpc_pkg::CHAN_W-1:0]     in_alpha,
  input  logic [rpc_pkg::COLOR_W-1:0]    in_packed_565,
  input  logic [rpc_pkg::COORD_W-1:0]    in_column,
  input  logic [rpc_pkg::COORD_W-1:0]    in_row,
  output logic                           item_valid,
  output rpc_pkg::rpc_item_t             item,
  input  logic                           item_full
);

  localparam int CROP = (SOURCE_SIZE - OUT_SIZE) / 2;
  localparam int CTR  = OUT_SIZE / 2;
  localparam int R2   = (CTR - 2) * (CTR - 2);
  localparam int OXW  = $clog2(OUT_SIZE);
  localparam int SQW  = 2 * OXW;
  localparam int AW   = (SQW > rpc_pkg::ADDR_W) ? SQW : rpc_pkg::ADDR_W;
  localparam int GW   = 12;

  localparam logic signed [GW-1:0] CROP_S = GW'(CROP);
  localparam logic signed [GW-1:0] OUT_S  = GW'(OUT_SIZE);
  localparam logic signed [OXW:0]  CTR_S  = (OXW + 1)'(CTR);

  logic fmt_r, fmt_nxt;
  logic adv;

  // stage 1 inputs
  logic [rpc_pkg::CHAN_W-1:0]  r, g, b, hi, lo;
  logic                        blank, warm;
  logic [rpc_pkg::COLOR_W-1:0] s1_color_nxt;
  logic signed [GW-1:0]        ox_s, oy_s;
  logic                        s1_inwin_nxt;
  logic [OXW-1:0]              s1_ox_nxt, s1_oy_nxt;
  logic signed [OXW:0]         s1_dx_nxt, s1_dy_nxt;

  logic                        s1_v_r, s1_v_nxt;
  logic [rpc_pkg::COLOR_W-1:0] s1_color_r;
  logic                        s1_fs_r, s1_inwin_r;
  logic [rpc_pkg::COORD_W-1:0] s1_col_r, s1_row_r;
  logic [OXW-1:0]              s1_ox_r, s1_oy_r;
  logic signed [OXW:0]         s1_dx_r, s1_dy_r;

  // stage 2
  logic [AW-1:0]               s2_prod_nxt;
  logic signed [2*OXW+1:0]     px, py;
  logic [SQW-1:0]              s2_sqx_nxt, s2_sqy_nxt;

  logic                        s2_v_r, s2_v_nxt;
  logic [rpc_pkg::COLOR_W-1:0] s2_color_r;
  logic                        s2_fs_r, s2_inwin_r;
  logic [rpc_pkg::COORD_W-1:0] s2_col_r, s2_row_r;
  logic [OXW-1:0]              s2_ox_r;
  logic [AW-1:0]               s2_prod_r;
  logic [SQW-1:0]              s2_sqx_r, s2_sqy_r;

  // stage 3
  logic [SQW:0]                rad_sq;
  logic [AW-1:0]               addr_full;
  rpc_pkg::rpc_item_t          s3_item_nxt, s3_item_r;
  logic                        s3_v_r, s3_v_nxt;

  assign cfg_ready  = 1'b1;
  assign adv        = !(s3_v_r && item_full);
  assign in_full    = !adv;
  assign item_valid = s3_v_r;
  assign item       = s3_item_r;

  assign fmt_nxt = (cfg_valid && cfg_ready) ? cfg_source_format : fmt_r;

  always_comb begin
    if (fmt_r) begin
      r     = {in_packed_565[15:11], 3'b000};
      g     = {in_packed_565[10:5], 2'b00};
      b     = {in_packed_565[4:0], 3'b000};
      blank = (in_packed_565 == '0);
    end else begin
      r     = in_red;
      g     = in_green;
      b     = in_blue;
      blank = (in_alpha < 8'd8);
    end
    hi = (r > g) ? r : g;
    if (b > hi) hi = b;
    lo = (r < g) ? r : g;
    if (b < lo) lo = b;
    warm = (r >= 8'd100) && ({1'b0, r} > {1'b0, b} + 9'd40);

    if (blank || (r < 8'd8 && g < 8'd8 && b < 8'd8)) begin
      s1_color_nxt = '0;
    end else if ((hi - lo) < 8'd70 && hi > 8'd60) begin
      s1_color_nxt = rpc_pkg::TRACE_COLOR;
    end else if (r > 8'd200 && b > 8'd200) begin
      s1_color_nxt = rpc_pkg::MAGENTA_COLOR;
    end else if (warm) begin
      if (g >= 8'd8) begin
        s1_color_nxt = rpc_pkg::PALETTE[{1'b1, rpc_pkg::WARM_G_TAB[g]}];
      end else begin
        s1_color_nxt = rpc_pkg::PALETTE[{1'b1, rpc_pkg::WARM_R_TAB[r]}];
      end
    end else begin
      s1_color_nxt = rpc_pkg::PALETTE[{1'b0, rpc_pkg::COOL_G_TAB[g]}];
    end
  end

  always_comb begin
    ox_s = $signed({3'b000, in_column}) - CROP_S;
    oy_s = $signed({3'b000, in_row}) - CROP_S;
    s1_inwin_nxt = !ox_s[GW-1] && (ox_s < OUT_S) && !oy_s[GW-1] && (oy_s < OUT_S);
    s1_ox_nxt = ox_s[OXW-1:0];
    s1_oy_nxt = oy_s[OXW-1:0];
    s1_dx_nxt = $signed({1'b0, s1_ox_nxt}) - CTR_S;
    s1_dy_nxt = $signed({1'b0, s1_oy_nxt}) - CTR_S;
  end

  always_comb begin
    s2_prod_nxt = AW'(s1_oy_r) * AW'(OUT_SIZE);
    px          = s1_dx_r * s1_dx_r;
    py          = s1_dy_r * s1_dy_r;
    s2_sqx_nxt  = px[SQW-1:0];
    s2_sqy_nxt  = py[SQW-1:0];
  end

  always_comb begin
    rad_sq    = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
    addr_full = s2_prod_r + AW'(s2_ox_r);
    s3_item_nxt.frame_start = s2_fs_r;
    s3_item_nxt.nonzero     = (s2_color_r != '0);
    s3_item_nxt.col         = s2_col_r;
    s3_item_nxt.row         = s2_row_r;
    s3_item_nxt.enable      = s2_inwin_r;
    s3_item_nxt.addr        = s2_inwin_r ? addr_full[rpc_pkg::ADDR_W-1:0] : '0;
    s3_item_nxt.written     = (s2_inwin_r && rad_sq <= (SQW + 1)'(R2)) ? s2_color_r : '0;
  end

  assign s1_v_nxt = adv ? (in_push && !in_full) : s1_v_r;
  assign s2_v_nxt = adv ? s1_v_r : s2_v_r;
  assign s3_v_nxt = adv ? s2_v_r : s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      fmt_r  <= fmt_nxt;
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_color_r <= s1_color_nxt;
      s1_fs_r    <= in_frame_start;
      s1_col_r   <= in_column;
      s1_row_r   <= in_row;
      s1_inwin_r <= s1_inwin_nxt;
      s1_ox_r    <= s1_ox_nxt;
      s1_oy_r    <= s1_oy_nxt;
      s1_dx_r    <= s1_dx_nxt;
      s1_dy_r    <= s1_dy_nxt;

      s2_color_r <= s1_color_r;
      s2_fs_r    <= s1_fs_r;
      s2_col_r   <= s1_col_r;
      s2_row_r   <= s1_row_r;
      s2_inwin_r <= s1_inwin_r;
      s2_ox_r    <= s1_ox_r;
      s2_prod_r  <= s2_prod_nxt;
      s2_sqx_r   <= s2_sqx_nxt;
      s2_sqy_r   <= s2_sqy_nxt;

      s3_item_r  <= s3_item_nxt;
    end
  end

  a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && (s3_item_r.written != '0) |-> s3_item_r.enable && s3_item_r.nonzero)
    else $error("pixel drawn outside crop window");

endmodule

// File: hdl/rpc_back.sv
module rpc_back #(
  parameter int SOURCE_SIZE = rpc_pkg::SOURCE_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  rpc_pkg::rpc_item_t   mid_item,
  output logic                 mid_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output rpc_pkg::rpc_result_t res
);

  localparam int SCW = rpc_pkg::SRC_CNT_W;
  localparam int DCW = rpc_pkg::DRAWN_CNT_W;
  localparam int LW  = rpc_pkg::LEAST_W;
  localparam int BW  = rpc_pkg::BOX_W;

  logic take;

  logic [SCW-1:0]       src_cnt_r, src_cnt_nxt, src_base;
  logic [DCW-1:0]       drawn_cnt_r, drawn_cnt_nxt, drawn_base;
  logic [LW-1:0]        least_x_r, least_x_nxt, least_x_base;
  logic [LW-1:0]        least_y_r, least_y_nxt, least_y_base;
  logic signed [BW-1:0] great_x_r, great_x_nxt, great_x_base;
  logic signed [BW-1:0] great_y_r, great_y_nxt, great_y_base;
  logic [LW-1:0]        col_u, row_u;
  logic signed [BW-1:0] col_s, row_s;

  assign take     = !mid_empty && !res_full;
  assign mid_pop  = take;
  assign res_push = take;

  always_comb begin
    if (mid_item.frame_start) begin
      src_base     = '0;
      drawn_base   = '0;
      least_x_base = LW'(SOURCE_SIZE);
      least_y_base = LW'(SOURCE_SIZE);
      great_x_base = '1;
      great_y_base = '1;
    end else begin
      src_base     = src_cnt_r;
      drawn_base   = drawn_cnt_r;
      least_x_base = least_x_r;
      least_y_base = least_y_r;
      great_x_base = great_x_r;
      great_y_base = great_y_r;
    end

    col_u = LW'(mid_item.col);
    row_u = LW'(mid_item.row);
    col_s = $signed({1'b0, mid_item.col});
    row_s = $signed({1'b0, mid_item.row});

    src_cnt_nxt   = src_base;
    drawn_cnt_nxt = drawn_base;
    least_x_nxt   = least_x_base;
    least_y_nxt   = least_y_base;
    great_x_nxt   = great_x_base;
    great_y_nxt   = great_y_base;

    if (mid_item.nonzero) begin
      if (src_base != '1) src_cnt_nxt = src_base + 1'b1;
      if (col_u < least_x_base) least_x_nxt = col_u;
      if (row_u < least_y_base) least_y_nxt = row_u;
      if (col_s > great_x_base) great_x_nxt = col_s;
      if (row_s > great_y_base) great_y_nxt = row_s;
    end
    if (mid_item.written != '0 && drawn_base != '1) begin
      drawn_cnt_nxt = drawn_base + 1'b1;
    end

    res.enable       = mid_item.enable;
    res.addr         = mid_item.addr;
    res.color        = mid_item.written;
    res.source_count = src_cnt_nxt;
    res.drawn_count  = drawn_cnt_nxt;
    res.box_min_x    = least_x_nxt[BW-1:0];
    res.box_min_y    = least_y_nxt[BW-1:0];
    res.box_max_x    = great_x_nxt;
    res.box_max_y    = great_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_cnt_r   <= '0;
      drawn_cnt_r <= '0;
      least_x_r   <= LW'(SOURCE_SIZE);
      least_y_r   <= LW'(SOURCE_SIZE);
      great_x_r   <= '1;
      great_y_r   <= '1;
    end else if (take) begin
      src_cnt_r   <= src_cnt_nxt;
      drawn_cnt_r <= drawn_cnt_nxt;
      least_x_r   <= least_x_nxt;
      least_y_r   <= least_y_nxt;
      great_x_r   <= great_x_nxt;
      great_y_r   <= great_y_nxt;
    end
  end

  a_drawn_le_src: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, drawn_cnt_r} <= src_cnt_r)
    else $error("drawn count ahead of source count");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    take && mid_item.frame_start && !mid_item.nonzero
      |=> src_cnt_r == '0 && great_x_r == '1 && great_y_r == '1)
    else $error("frame start did not clear state");

  a_box_set: assert property (@(posedge clk) disable iff (!rst_n)
    take && mid_item.nonzero |=> !great_x_r[BW-1] && !great_y_r[BW-1] && src_cnt_r != '0)
    else $error("bounding box not updated by nonzero pixel");

endmodule

// File: hdl/radar_pixel_recolor_crop.sv
// Radar pixel recolor and crop.
// Input channel: present one source pixel with in_push; it is taken on a clock
// edge where in_push is high and in_full is low. cfg_source_format picks the
// RGBA fields (0) or in_packed_565 (1); write it through cfg_valid/cfg_ready
// (always ready) while no pixel is in flight.
// Result channel: while out_empty is low the oldest result is on the out_
// ports; out_pop takes it. One result comes back for every pixel, in order.
// Path: a pixel passes the three front stages (recolor and geometry), the
// queue between front and back, and the counter update in the back, which
// writes the result queue that drives the out_ ports.
// Throughput: one pixel per cycle through the front pipeline and the counter
// update while nothing stalls; both queues move one transaction a cycle.
// Reset: counters clear, bounding box goes to none, format returns to RGBA,
// all queues empty. No clearing pass is needed.
// Stall: when out_pop stays low the two-entry result queue fills, then the
// four-entry queue between front and back, then the front pipeline holds and
// in_full rises; nothing is dropped.
module radar_pixel_recolor_crop #(
  parameter int SOURCE_SIZE = rpc_pkg::SOURCE_SIZE_DEF,
  parameter int OUT_SIZE    = rpc_pkg::OUT_SIZE_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_source_format,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic                                 in_frame_start,
  input  logic [rpc_pkg::CHAN_W-1:0]           in_red,
  input  logic [rpc_pkg::CHAN_W-1:0]           in_green,
  input  logic [rpc_pkg::CHAN_W-1:0]           in_blue,
  input  logic [rpc_pkg::CHAN_W-1:0]           in_alpha,
  input  logic [rpc_pkg::COLOR_W-1:0]          in_packed_565,
  input  logic [rpc_pkg::COORD_W-1:0]          in_column,
  input  logic [rpc_pkg::COORD_W-1:0]          in_row,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic                                 out_write_enable,
  output logic [rpc_pkg::ADDR_W-1:0]           out_write_address,
  output logic [rpc_pkg::COLOR_W-1:0]          out_color,
  output logic [rpc_pkg::SRC_CNT_W-1:0]        out_source_count,
  output logic [rpc_pkg::DRAWN_CNT_W-1:0]      out_drawn_count,
  output logic [rpc_pkg::BOX_W-1:0]            out_box_min_x,
  output logic [rpc_pkg::BOX_W-1:0]            out_box_min_y,
  output logic signed [rpc_pkg::BOX_W-1:0]     out_box_max_x,
  output logic signed [rpc_pkg::BOX_W-1:0]     out_box_max_y
);

  localparam int ITEM_W = $bits(rpc_pkg::rpc_item_t);
  localparam int RES_W  = $bits(rpc_pkg::rpc_result_t);

  logic                 front_valid, mid_full, mid_empty, mid_pop;
  rpc_pkg::rpc_item_t   front_item, mid_item;
  logic                 res_full, res_push;
  rpc_pkg::rpc_result_t res_in, res_out;

  rpc_front #(
    .SOURCE_SIZE (SOURCE_SIZE),
    .OUT_SIZE    (OUT_SIZE)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_source_format (cfg_source_format),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_frame_start    (in_frame_start),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .in_packed_565     (in_packed_565),
    .in_column         (in_column),
    .in_row            (in_row),
    .item_valid        (front_valid),
    .item              (front_item),
    .item_full         (mid_full)
  );

  rpc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (rpc_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (front_valid),
    .wr_data (front_item),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_item),
    .empty   (mid_empty)
  );

  rpc_back #(
    .SOURCE_SIZE (SOURCE_SIZE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_item),
    .mid_pop   (mid_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  rpc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (rpc_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_out),
    .empty   (out_empty)
  );

  assign out_write_enable  = res_out.enable;
  assign out_write_address = res_out.addr;
  assign out_color         = res_out.color;
  assign out_source_count  = res_out.source_count;
  assign out_drawn_count   = res_out.drawn_count;
  assign out_box_min_x     = res_out.box_min_x;
  assign out_box_min_y     = res_out.box_min_y;
  assign out_box_max_x     = res_out.box_max_x;
  assign out_box_max_y     = res_out.box_max_y;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int SRC_SIZE  = rpc_pkg::SOURCE_SIZE_DEF;
  localparam int CROP_SIZE = rpc_pkg::OUT_SIZE_DEF;
  localparam int CROP      = (SRC_SIZE - CROP_SIZE) / 2;
  localparam int HALF      = CROP_SIZE / 2;
  localparam int CENTER    = CROP + HALF;
  localparam int SRC_MAX   = (1 << rpc_pkg::SRC_CNT_W) - 1;
  localparam int DRAWN_MAX = (1 << rpc_pkg::DRAWN_CNT_W) - 1;
  localparam int CYCLE_LIMIT = 200000;

  localparam bit FMT_RGBA = 1'b0;
  localparam bit FMT_565  = 1'b1;

  localparam int EDGE_COORD [6] = '{CROP - 1, CROP, CROP + 1,
                                    CROP + CROP_SIZE - 2, CROP + CROP_SIZE - 1,
                                    CROP + CROP_SIZE};

  typedef struct {
    bit        frame_start;
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [7:0]  alpha;
    bit [15:0] packed_565;
    bit [8:0]  column;
    bit [8:0]  row;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_source_format = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_frame_start = 1'b0;
  logic [rpc_pkg::CHAN_W-1:0] in_red = '0;
  logic [rpc_pkg::CHAN_W-1:0] in_green = '0;
  logic [rpc_pkg::CHAN_W-1:0] in_blue = '0;
  logic [rpc_pkg::CHAN_W-1:0] in_alpha = '0;
  logic [rpc_pkg::COLOR_W-1:0] in_packed_565 = '0;
  logic [rpc_pkg::COORD_W-1:0] in_column = '0;
  logic [rpc_pkg::COORD_W-1:0] in_row = '0;
  logic out_pop = 1'b0;
  logic out_empty;
  logic out_write_enable;
  logic [rpc_pkg::ADDR_W-1:0] out_write_address;
  logic [rpc_pkg::COLOR_W-1:0] out_color;
  logic [rpc_pkg::SRC_CNT_W-1:0] out_source_count;
  logic [rpc_pkg::DRAWN_CNT_W-1:0] out_drawn_count;
  logic [rpc_pkg::BOX_W-1:0] out_box_min_x;
  logic [rpc_pkg::BOX_W-1:0] out_box_min_y;
  logic signed [rpc_pkg::BOX_W-1:0] out_box_max_x;
  logic signed [rpc_pkg::BOX_W-1:0] out_box_max_y;

  pixel_t src_pixels [$];
  pixel_t cur_pixel;
  rpc_pkg::rpc_result_t radar_due [$];
  rpc_pkg::rpc_result_t want;

  logic [15:0] radar_palette [16];
  logic [15:0] trace_rgb;
  bit fmt_now = FMT_RGBA;
  int pixel_total, drawn_total;
  int least_col, least_row, most_col, most_row;

  int idle_pct = 0;
  int send_gap = 0;
  int pop_gap = 0;
  int mismatches = 0;
  int results_seen = 0;
  int cycles = 0;

  radar_pixel_recolor_crop #(
    .SOURCE_SIZE(SRC_SIZE),
    .OUT_SIZE   (CROP_SIZE)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_source_format(cfg_source_format),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_frame_start   (in_frame_start),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_alpha         (in_alpha),
    .in_packed_565    (in_packed_565),
    .in_column        (in_column),
    .in_row           (in_row),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_write_enable (out_write_enable),
    .out_write_address(out_write_address),
    .out_color        (out_color),
    .out_source_count (out_source_count),
    .out_drawn_count  (out_drawn_count),
    .out_box_min_x    (out_box_min_x),
    .out_box_min_y    (out_box_min_y),
    .out_box_max_x    (out_box_max_x),
    .out_box_max_y    (out_box_max_y)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [15:0] to565(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic int ramp_clamp(int t);
    if (t < 0) return 0;
    if (t > 1000) return 1000;
    return t;
  endfunction

  function automatic logic [15:0] radar_shade(int r, int g, int b);
    int hi, lo, t;
    if (r < 8 && g < 8 && b < 8) return 16'h0000;
    hi = (r > g) ? r : g;
    if (b > hi) hi = b;
    lo = (r < g) ? r : g;
    if (b < lo) lo = b;
    if (hi - lo < 70 && hi > 60) return trace_rgb;
    if (r > 200 && b > 200) return radar_palette[15];
    if (r >= 100 && r > b + 40) begin
      if (g >= 8) t = ((238 - g) * 665) / 238;
      else t = 665 + ((255 - r) * 335) / 162;
      t = ramp_clamp(t);
      return radar_palette[8 + (t * 8) / 1001];
    end
    t = ramp_clamp(((221 - g) * 1000) / 150);
    return radar_palette[(t * 8) / 1001];
  endfunction

  function automatic void clear_frame_stats();
    pixel_total = 0;
    drawn_total = 0;
    least_col = SRC_SIZE;
    least_row = SRC_SIZE;
    most_col = -1;
    most_row = -1;
  endfunction

  function automatic rpc_pkg::rpc_result_t predict_radar(pixel_t p);
    rpc_pkg::rpc_result_t res;
    logic [15:0] shade;
    int col, row, ox, oy, dx, dy;
    res = '0;
    col = int'(p.column);
    row = int'(p.row);
    if (p.frame_start) clear_frame_stats();
    if (fmt_now == FMT_RGBA) begin
      shade = (p.alpha < 8) ? 16'h0000 :
              radar_shade(int'(p.red), int'(p.green), int'(p.blue));
    end else if (p.packed_565 == 16'h0000) begin
      shade = 16'h0000;
    end else begin
      shade = radar_shade(int'({p.packed_565[15:11], 3'b000}),
                          int'({p.packed_565[10:5], 2'b00}),
                          int'({p.packed_565[4:0], 3'b000}));
    end
    if (shade != 16'h0000) begin
      if (pixel_total < SRC_MAX) pixel_total++;
      if (col < least_col) least_col = col;
      if (col > most_col) most_col = col;
      if (row < least_row) least_row = row;
      if (row > most_row) most_row = row;
    end
    ox = col - CROP;
    oy = row - CROP;
    if (ox >= 0 && ox < CROP_SIZE && oy >= 0 && oy < CROP_SIZE) begin
      res.enable = 1'b1;
      res.addr = rpc_pkg::ADDR_W'(oy * CROP_SIZE + ox);
      dx = ox - HALF;
      dy = oy - HALF;
      if (dx * dx + dy * dy <= (HALF - 2) * (HALF - 2)) res.color = shade;
      if (res.color != 16'h0000 && drawn_total < DRAWN_MAX) drawn_total++;
    end
    res.source_count = rpc_pkg::SRC_CNT_W'(pixel_total);
    res.drawn_count = rpc_pkg::DRAWN_CNT_W'(drawn_total);
    res.box_min_x = rpc_pkg::BOX_W'(least_col);
    res.box_min_y = rpc_pkg::BOX_W'(least_row);
    res.box_max_x = rpc_pkg::BOX_W'(most_col);
    res.box_max_y = rpc_pkg::BOX_W'(most_row);
    return res;
  endfunction

  function automatic pixel_t make_pixel(int fs, int r, int g, int b,
                                        int a, int pk, int col, int row);
    pixel_t p;
    p.frame_start = (fs != 0);
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    p.alpha = 8'(a);
    p.packed_565 = 16'(pk);
    p.column = 9'(col);
    p.row = 9'(row);
    return p;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    int v, span, dy;
    p.frame_start = ($urandom_range(0, 39) == 0);
    p.red = 8'($urandom);
    p.green = 8'($urandom);
    p.blue = 8'($urandom);
    p.alpha = 8'($urandom_range(8, 255));
    case ($urandom_range(0, 9))
      0: p.alpha = 8'($urandom_range(0, 7));
      1: begin
        p.red = 8'($urandom_range(0, 8));
        p.green = 8'($urandom_range(0, 8));
        p.blue = 8'($urandom_range(0, 8));
      end
      2: begin
        v = $urandom_range(40, 255);
        span = (v < 75) ? v : 75;
        p.red = 8'(v - $urandom_range(0, span));
        p.green = 8'(v - $urandom_range(0, span));
        p.blue = 8'(v - $urandom_range(0, span));
      end
      3: begin
        p.red = 8'($urandom_range(190, 255));
        p.blue = 8'($urandom_range(190, 255));
      end
      4: begin
        p.red = 8'($urandom_range(100, 255));
        p.blue = 8'($urandom_range(0, p.red - 41));
      end
      5: begin
        p.red = 8'($urandom_range(100, 255));
        p.green = 8'($urandom_range(0, 9));
        p.blue = 8'($urandom_range(0, 60));
      end
      6: p.red = 8'($urandom_range(0, 120));
      default: p.alpha = 8'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0: p.packed_565 = 16'h0000;
      1, 2: p.packed_565 = to565(p.red, p.green, p.blue);
      default: p.packed_565 = 16'($urandom);
    endcase
    p.column = 9'($urandom);
    p.row = 9'($urandom);
    case ($urandom_range(0, 7))
      0: p.column = 9'(EDGE_COORD[$urandom_range(0, 5)]);
      1: p.row = 9'(EDGE_COORD[$urandom_range(0, 5)]);
      2: begin
        p.row = 9'($urandom_range(CENTER - HALF + 2, CENTER + HALF - 2));
        dy = int'(p.row) - CENTER;
        v = int'($floor($sqrt(real'((HALF - 2) * (HALF - 2) - dy * dy))));
        p.column = 9'(CENTER + ($urandom_range(0, 1) ? v : -v) + $urandom_range(0, 1));
      end
      3: begin
        p.column = 9'($urandom_range(0, 1) ? SRC_SIZE - 1 : 0);
        p.row = 9'($urandom_range(0, 1) ? SRC_SIZE - 1 : 0);
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] exp_val);
    if (got !== exp_val)
      flag_mismatch($sformatf("result %0d %s got %0h want %0h", results_seen, name, got,
                              exp_val));
  endtask

  task automatic wait_all_results();
    do @(negedge clk); while (src_pixels.size() != 0 || in_push || radar_due.size() != 0);
  endtask

  task automatic set_source_format(input bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_source_format <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fmt_now = v;
    @(negedge clk);
  endtask

  task automatic queue_random(input int n, input int pct);
    idle_pct = pct;
    repeat (n) src_pixels.push_back(random_pixel());
  endtask

  // driver: predict on each accepted transaction, then load the next pixel
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap = 0;
      fmt_now = FMT_RGBA;
      clear_frame_stats();
    end else begin
      if (in_push && !in_full) radar_due.push_back(predict_radar(cur_pixel));
      if (!in_push || !in_full) begin
        if (send_gap > 0) begin
          send_gap--;
          in_push <= 1'b0;
        end else if (src_pixels.size() > 0) begin
          cur_pixel = src_pixels.pop_front();
          in_frame_start <= cur_pixel.frame_start;
          in_red <= cur_pixel.red;
          in_green <= cur_pixel.green;
          in_blue <= cur_pixel.blue;
          in_alpha <= cur_pixel.alpha;
          in_packed_565 <= cur_pixel.packed_565;
          in_column <= cur_pixel.column;
          in_row <= cur_pixel.row;
          in_push <= 1'b1;
          if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            send_gap = $urandom_range(1, 4);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each popped transaction with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap = 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (radar_due.size() == 0) begin
          flag_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = radar_due.pop_front();
          check_field("write_enable", 32'(out_write_enable), 32'(want.enable));
          check_field("write_address", 32'(out_write_address), 32'(want.addr));
          check_field("color", 32'(out_color), 32'(want.color));
          check_field("source_count", 32'(out_source_count), 32'(want.source_count));
          check_field("drawn_count", 32'(out_drawn_count), 32'(want.drawn_count));
          check_field("box_min_x", 32'(out_box_min_x), 32'(want.box_min_x));
          check_field("box_min_y", 32'(out_box_min_y), 32'(want.box_min_y));
          check_field("box_max_x", 32'(out_box_max_x), 32'(want.box_max_x));
          check_field("box_max_y", 32'(out_box_max_y), 32'(want.box_max_y));
        end
        results_seen++;
      end
      if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) pop_gap = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    trace_rgb = to565(8'h1E, 8'h46, 8'h20);
    radar_palette = '{
      to565(8'h6E, 8'hFF, 8'h6E), to565(8'h35, 8'hFF, 8'h35),
      to565(8'h02, 8'hFD, 8'h02), to565(8'h01, 8'hE1, 8'h01),
      to565(8'h01, 8'hC5, 8'h01), to565(8'h00, 8'hAC, 8'h00),
      to565(8'h00, 8'h9A, 8'h00), to565(8'h00, 8'h8E, 8'h00),
      to565(8'hFD, 8'hF8, 8'h02), to565(8'hF2, 8'hD8, 8'h00),
      to565(8'hE5, 8'hBC, 8'h00), to565(8'hFD, 8'h95, 8'h00),
      to565(8'hFD, 8'h60, 8'h00), to565(8'hFD, 8'h00, 8'h00),
      to565(8'hBC, 8'h00, 8'h00), to565(8'hF8, 8'h00, 8'hFD)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    set_source_format(FMT_RGBA);
    idle_pct = 30;
    src_pixels.push_back(make_pixel(1, 0, 0, 0, 0, $urandom, 0, 0));
    src_pixels.push_back(make_pixel(0, 255, 255, 255, 7, $urandom, 511, 511));
    src_pixels.push_back(make_pixel(0, 7, 7, 7, 255, $urandom, CROP, CROP));
    src_pixels.push_back(make_pixel(0, 100, 100, 100, 255, $urandom, 495, 495));
    src_pixels.push_back(make_pixel(0, 50, 50, 50, 255, $urandom, CROP - 1, CENTER));
    src_pixels.push_back(make_pixel(0, 255, 0, 255, 255, $urandom, CENTER, CENTER));
    src_pixels.push_back(make_pixel(0, 255, 100, 0, 255, $urandom, CENTER + HALF - 2, CENTER));
    src_pixels.push_back(make_pixel(0, 200, 0, 0, 255, $urandom, CENTER + HALF - 1, CENTER));
    src_pixels.push_back(make_pixel(0, 0, 255, 0, 255, $urandom, CENTER, CROP));
    src_pixels.push_back(make_pixel(0, 0, 221, 0, 8, $urandom, CENTER, CROP + 2));
    src_pixels.push_back(make_pixel(0, 0, 0, 255, 128, $urandom, CENTER, CROP + CROP_SIZE));
    src_pixels.push_back(make_pixel(1, 255, 255, 0, 255, $urandom, 300, 100));
    src_pixels.push_back(make_pixel(0, 0, 100, 255, 255, $urandom, CROP + 1, 494));
    src_pixels.push_back(make_pixel(0, 150, 8, 0, 255, $urandom, 511, 0));
    src_pixels.push_back(make_pixel(0, 255, 7, 40, 200, $urandom, 0, 511));
    wait_all_results();

    set_source_format(FMT_565);
    idle_pct = 0;
    src_pixels.push_back(make_pixel(1, $urandom, $urandom, $urandom, $urandom, 16'h0000,
                                    CENTER, CENTER));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'hFFFF, 0, 511));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, 0, 16'hF81F, CENTER, CENTER));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'h07E0, 100, 200));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'h001F, 511, 16));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'hF800, 200, 300));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'h0001, 20, 20));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'hFC00, 495, 15));
    src_pixels.push_back(make_pixel(0, $urandom, $urandom, $urandom, $urandom, 16'h0020, 300, 300));
    wait_all_results();

    set_source_format(FMT_RGBA);
    queue_random(750, 25);
    wait_all_results();

    set_source_format(FMT_565);
    queue_random(700, 40);
    wait_all_results();

    // hold both sides busy for the tail
    set_source_format(FMT_RGBA);
    queue_random(280, 0);
    wait_all_results();

    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: sim.f
hdl/rpc_pkg.sv
hdl/rpc_fifo.sv
hdl/rpc_front.sv
hdl/rpc_back.sv
hdl/radar_pixel_recolor_crop.sv
tb/tb.sv
